>>> sv/sst_pkg.sv
// Shared types and constants for the station statistics table.
// Used by the sequencer, the table memory, the divider, the top level and the checker.
`timescale 1ns / 1ps

package sst_pkg;

   localparam int ADDR_W   = 48;
   localparam int LOSS_W   = 16;
   localparam int RATE_W   = 32;
   localparam int BYTES_W  = 32;
   localparam int IVAL_W   = 16;
   localparam int SCALE_W  = 10;
   localparam int PROD_W   = BYTES_W + SCALE_W;

   localparam logic [LOSS_W-1:0]  MISS_LOSS      = 16'hFF00;
   localparam logic [RATE_W-1:0]  ALL_ONES_RATE  = 32'hFFFF_FFFF;
   localparam logic [SCALE_W-1:0] RATE_SCALE     = 10'd1000;
   localparam logic [IVAL_W-1:0]  INTERVAL_RESET = 16'd1000;

   typedef enum logic [2:0] {
      KIND_APPEND,
      KIND_SET_LOSS,
      KIND_SET_RATE,
      KIND_ADD_BYTES,
      KIND_QUERY,
      KIND_RESET_COUNTS,
      KIND_RECOMPUTE,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_APPLY,
      ST_ZERO,
      ST_RC_RD,
      ST_RC_MUL,
      ST_RC_DIV,
      ST_RC_SRCH_RD,
      ST_RC_SRCH_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [LOSS_W-1:0]  loss;
      logic [RATE_W-1:0]  rate;
      logic [BYTES_W-1:0] bytes;
   } entry_type;

   typedef struct packed {
      logic addr;
      logic loss;
      logic rate;
      logic bytes;
   } wr_en_type;

   typedef struct packed {
      logic               found;
      logic [LOSS_W-1:0]  loss;
      logic [RATE_W-1:0]  rate;
      logic               status;
   } result_type;

endpackage

>>> sv/sst_mem.sv
// Station table storage: one array per entry field, one registered read port
// and one write port with per-field enables. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_mem #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IW-1:0]       rd_idx,
   output sst_pkg::entry_type  rd_data,
   input  sst_pkg::wr_en_type  wr_en,
   input  logic [IW-1:0]       wr_idx,
   input  sst_pkg::entry_type  wr_data
);
   import sst_pkg::*;

   logic [ADDR_W-1:0]  addr_mem  [DEPTH];
   logic [LOSS_W-1:0]  loss_mem  [DEPTH];
   logic [RATE_W-1:0]  rate_mem  [DEPTH];
   logic [BYTES_W-1:0] bytes_mem [DEPTH];

   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en.addr) begin
         addr_mem[wr_idx] <= wr_data.addr;
      end
      if (wr_en.loss) begin
         loss_mem[wr_idx] <= wr_data.loss;
      end
      if (wr_en.rate) begin
         rate_mem[wr_idx] <= wr_data.rate;
      end
      if (wr_en.bytes) begin
         bytes_mem[wr_idx] <= wr_data.bytes;
      end
   end

   // The read data holds between reads; the sequencer relies on that.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.addr  <= addr_mem[rd_idx];
         rd_data_ff.loss  <= loss_mem[rd_idx];
         rd_data_ff.rate  <= rate_mem[rd_idx];
         rd_data_ff.bytes <= bytes_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sst_div.sv
// Restoring divider, one quotient bit per cycle, for the scaled byte count
// over the measurement interval. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sst_pkg::PROD_W-1:0]  dividend,
   input  logic [sst_pkg::IVAL_W-1:0]  divisor,
   output logic                        done,
   output logic [sst_pkg::PROD_W-1:0]  quotient
);
   import sst_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [IVAL_W-1:0] rem_ff, rem_in;
   logic [IVAL_W-1:0] div_ff, div_in;
   logic [IVAL_W:0]   rem_sh;
   logic [IVAL_W:0]   diff;

   always_comb begin
      rem_sh    = {rem_ff, quo_ff[PROD_W-1]};
      diff      = rem_sh - {1'b0, div_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(PROD_W - 1);
         quo_in    = dividend;
         rem_in    = '0;
         div_in    = divisor;
      end else if (active_ff) begin
         // The remainder stays below the divisor, so it fits in IVAL_W bits.
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = diff[IVAL_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[IVAL_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/sst_seq.sv
// Sequencer of the station table: address search, queries, updates, inserts, clear, count
// reset and rate recompute, one entry at a time. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_seq #(
   parameter int ENTRIES = 16,
   parameter int IW      = 4,
   parameter int CW      = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   kind,
   input  logic [sst_pkg::ADDR_W-1:0]   station_addr,
   input  logic [sst_pkg::LOSS_W-1:0]   loss_value,
   input  logic [sst_pkg::RATE_W-1:0]   rate_value,
   input  logic [sst_pkg::BYTES_W-1:0]  byte_amount,
   input  logic [sst_pkg::IVAL_W-1:0]   interval,
   output logic                         rsp_valid,
   output sst_pkg::result_type          rsp,
   output logic                         rd_en,
   output logic [IW-1:0]                rd_idx,
   input  sst_pkg::entry_type           rd_data,
   output sst_pkg::wr_en_type           wr_en,
   output logic [IW-1:0]                wr_idx,
   output sst_pkg::entry_type           wr_data,
   output logic                         div_start,
   output logic [sst_pkg::PROD_W-1:0]   div_dividend,
   input  logic                         div_done,
   input  logic [sst_pkg::PROD_W-1:0]   div_quot
);
   import sst_pkg::*;

   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [ADDR_W-1:0]  key_ff, key_in;
   logic [LOSS_W-1:0]  loss_ff, loss_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [CW-1:0]      walk_ff, walk_in;
   logic               hit_ff, hit_in;
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic [RATE_W-1:0]  new_rate_ff, new_rate_in;
   result_type         res_ff, res_in;

   logic scan_valid;
   logic walk_valid;
   logic key_match;
   logic cur_match;

   assign scan_valid = scan_ff < fill_ff;
   assign walk_valid = walk_ff < fill_ff;
   assign key_match  = rd_data.addr == key_ff;
   assign cur_match  = rd_data.addr == cur_addr_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (kind_type'(kind))
                  KIND_APPEND, KIND_SET_LOSS, KIND_SET_RATE, KIND_ADD_BYTES,
                  KIND_QUERY:        state_in = ST_SRCH_RD;
                  KIND_RESET_COUNTS: state_in = ST_ZERO;
                  KIND_RECOMPUTE:    state_in = ST_RC_RD;
                  default:           state_in = ST_DONE;
               endcase
            end
         end
         ST_SRCH_RD:     state_in = scan_valid ? ST_SRCH_CMP : ST_APPLY;
         ST_SRCH_CMP:    state_in = key_match ? ST_APPLY : ST_SRCH_RD;
         ST_APPLY:       state_in = ST_DONE;
         ST_ZERO:        state_in = walk_valid ? ST_ZERO : ST_DONE;
         ST_RC_RD:       state_in = walk_valid ? ST_RC_MUL : ST_DONE;
         ST_RC_MUL:      state_in = (interval != '0) ? ST_RC_DIV : ST_RC_SRCH_RD;
         ST_RC_DIV:      state_in = div_done ? ST_RC_SRCH_RD : ST_RC_DIV;
         ST_RC_SRCH_RD:  state_in = ST_RC_SRCH_CMP;
         ST_RC_SRCH_CMP: state_in = cur_match ? ST_RC_RD : ST_RC_SRCH_RD;
         ST_DONE:        state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      logic ins;
      ins          = 1'b0;
      busy         = state_ff != ST_IDLE;
      rsp_valid    = state_ff == ST_DONE;
      rd_en        = 1'b0;
      rd_idx       = scan_ff[IW-1:0];
      wr_en        = '0;
      wr_idx       = scan_ff[IW-1:0];
      wr_data      = '0;
      div_start    = 1'b0;
      div_dividend = PROD_W'(rd_data.bytes) * PROD_W'(RATE_SCALE);
      kind_in      = kind_ff;
      key_in       = key_ff;
      loss_in      = loss_ff;
      rate_in      = rate_ff;
      bytes_in     = bytes_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      walk_in      = walk_ff;
      hit_in       = hit_ff;
      cur_addr_in  = cur_addr_ff;
      new_rate_in  = new_rate_ff;
      res_in       = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = kind_type'(kind);
               key_in   = station_addr;
               loss_in  = loss_value;
               rate_in  = rate_value;
               bytes_in = byte_amount;
               scan_in  = '0;
               walk_in  = '0;
               hit_in   = 1'b0;
               res_in   = '0;
               if (kind_type'(kind) == KIND_CLEAR) begin
                  fill_in = '0;
               end
            end
         end
         ST_SRCH_RD: begin
            if (scan_valid) begin
               rd_en = 1'b1;
            end
         end
         ST_SRCH_CMP: begin
            if (key_match) begin
               hit_in = 1'b1;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_APPLY: begin
            res_in.found = hit_ff;
            wr_data.addr = key_ff;
            case (kind_ff)
               KIND_APPEND: begin
                  ins           = 1'b1;
                  wr_data.loss  = loss_ff;
                  wr_data.rate  = rate_ff;
                  wr_data.bytes = bytes_ff;
               end
               KIND_SET_LOSS: begin
                  wr_data.loss = loss_ff;
                  ins          = !hit_ff;
                  wr_en.loss   = hit_ff;
               end
               KIND_SET_RATE: begin
                  wr_data.rate = rate_ff;
                  ins          = !hit_ff;
                  wr_en.rate   = hit_ff;
               end
               KIND_ADD_BYTES: begin
                  // On a hit the read data still holds the matched entry.
                  wr_data.bytes = hit_ff ? (rd_data.bytes + bytes_ff) : bytes_ff;
                  ins           = !hit_ff;
                  wr_en.bytes   = hit_ff;
               end
               KIND_QUERY: begin
                  res_in.loss = hit_ff ? rd_data.loss : MISS_LOSS;
                  res_in.rate = hit_ff ? rd_data.rate : ALL_ONES_RATE;
               end
               default: begin
                  ins = 1'b0;
               end
            endcase
            if (ins) begin
               if (fill_ff == FULL) begin
                  res_in.status = 1'b1;
               end else begin
                  wr_en   = '1;
                  wr_idx  = fill_ff[IW-1:0];
                  fill_in = fill_ff + CW'(1);
               end
            end
         end
         ST_ZERO: begin
            if (walk_valid) begin
               wr_en.bytes = 1'b1;
               wr_idx      = walk_ff[IW-1:0];
               walk_in     = walk_ff + CW'(1);
            end
         end
         ST_RC_RD: begin
            if (walk_valid) begin
               rd_en  = 1'b1;
               rd_idx = walk_ff[IW-1:0];
            end
         end
         ST_RC_MUL: begin
            cur_addr_in = rd_data.addr;
            scan_in     = '0;
            if (interval != '0) begin
               div_start = 1'b1;
            end else begin
               new_rate_in = ALL_ONES_RATE;
            end
         end
         ST_RC_DIV: begin
            if (div_done) begin
               new_rate_in = (div_quot[PROD_W-1:RATE_W] != '0) ? ALL_ONES_RATE
                                                               : div_quot[RATE_W-1:0];
            end
         end
         ST_RC_SRCH_RD: begin
            rd_en = 1'b1;
         end
         ST_RC_SRCH_CMP: begin
            // The visited entry itself matches, so this search always ends.
            if (cur_match) begin
               wr_en.rate   = 1'b1;
               wr_data.rate = new_rate_ff;
               walk_in      = walk_ff + CW'(1);
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_DONE: begin
            ins = 1'b0;
         end
         default: begin
            ins = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      loss_ff     <= loss_in;
      rate_ff     <= rate_in;
      bytes_ff    <= bytes_in;
      scan_ff     <= scan_in;
      walk_ff     <= walk_in;
      hit_ff      <= hit_in;
      cur_addr_ff <= cur_addr_in;
      new_rate_ff <= new_rate_in;
      res_ff      <= res_in;
   end

   assign rsp = res_ff;

endmodule

>>> sv/station_stats_table_top.sv
// Station statistics table, one item at a time, with a one-cycle result strobe. Query and
// updates compare the valid entries up to the first match, or all of them on a miss; clear
// empties the table; reset counts zeroes the byte count of every valid entry. Recompute, per
// entry: read, multiply, the one-bit-per-cycle divider (skipped when the interval is 0), then
// a search for the entry's first copy, whose rate is written. busy falls the cycle after the
// strobe; the receiver cannot stall. Synchronous reset empties the table.
`timescale 1ns / 1ps

module station_stats_table_top #(
   parameter int ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_kind,
   input  logic [sst_pkg::ADDR_W-1:0]   req_station_addr,
   input  logic signed [15:0]           req_loss_value,
   input  logic [sst_pkg::RATE_W-1:0]   req_rate_value,
   input  logic [sst_pkg::BYTES_W-1:0]  req_byte_amount,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic signed [15:0]           rsp_loss_out,
   output logic [sst_pkg::RATE_W-1:0]   rsp_rate_out,
   output logic                         rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sst_pkg::IVAL_W-1:0]   csr_data
);
   import sst_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic [IVAL_W-1:0] interval_ff, interval_in;

   logic              rd_en;
   logic [IW-1:0]     rd_idx;
   entry_type         rd_data;
   wr_en_type         wr_en;
   logic [IW-1:0]     wr_idx;
   entry_type         wr_data;
   logic              div_start;
   logic [PROD_W-1:0] div_dividend;
   logic              div_done;
   logic [PROD_W-1:0] div_quot;
   result_type        rsp;

   assign csr_ready   = 1'b1;
   assign interval_in = (csr_valid && csr_ready) ? csr_data : interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   sst_seq #(
      .ENTRIES (ENTRIES),
      .IW      (IW),
      .CW      (CW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .kind         (req_kind),
      .station_addr (req_station_addr),
      .loss_value   (req_loss_value),
      .rate_value   (req_rate_value),
      .byte_amount  (req_byte_amount),
      .interval     (interval_ff),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp),
      .rd_en        (rd_en),
      .rd_idx       (rd_idx),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_idx       (wr_idx),
      .wr_data      (wr_data),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_done     (div_done),
      .div_quot     (div_quot)
   );

   sst_mem #(
      .DEPTH (ENTRIES),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   sst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (interval_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_found    = rsp.found;
   assign rsp_loss_out = rsp.loss;
   assign rsp_rate_out = rsp.rate;
   assign rsp_status   = rsp.status;

endmodule

>>> sv/sst_checker.sv
// Port-level checks on the station table's command and result timing.
// Bound to station_stats_table_top; depends on sst_pkg.
`timescale 1ns / 1ps

module sst_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        rsp_valid,
   input  logic                        rsp_found,
   input  logic signed [15:0]          rsp_loss_out
);
   import sst_pkg::*;

   // An accepted item must raise busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted item");

   // A result is shown only while busy, and the block is free right after.
   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   a_result_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle or busy held");

   // Without a match the loss is either unused or the miss value.
   a_miss_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_loss_out == 16'sd0 || rsp_loss_out == $signed(MISS_LOSS)))
      else $error("unexpected loss value on a miss");

endmodule

bind station_stats_table_top sst_checker u_sst_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_found    (rsp_found),
   .rsp_loss_out (rsp_loss_out)
);
